FILE: src/hwsc_pkg.sv
// Shared constants, codes and control types of the history window search and compare block.
`default_nettype none

package hwsc_pkg;

   localparam int WINDOW_SIZE = 4096;
   localparam int ADDR_W      = $clog2(WINDOW_SIZE);
   localparam int LEN_W       = ADDR_W + 1;

   localparam int OFFSET_W    = 12;
   localparam int LENGTH_W    = 13;
   localparam int BYTE_W      = 8;
   localparam int DIFF_W      = 9;
   localparam int REQ_DATA_W  = 48;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 32;

   typedef enum logic [1:0] {
      OP_APPEND  = 2'd0,
      OP_READ    = 2'd1,
      OP_FIND    = 2'd2,
      OP_COMPARE = 2'd3
   } op_type;

   typedef struct packed {
      logic start;
      logic do_append;
      logic walk_en;
      logic load_out;
      logic clear_en;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_done;
      logic out_free;
   } sts_type;

   // Packed with found in the lowest bit, matching the result item layout.
   typedef struct packed {
      logic [DIFF_W-1:0]   compare_diff;
      logic [BYTE_W-1:0]   read_byte;
      logic [OFFSET_W-1:0] match_offset;
      logic                found;
   } result_type;

endpackage

`default_nettype wire

FILE: src/history_window_search_compare.sv
// Top level of the history window search and compare block.
//
// The block holds a 4096-byte history ring addressed by logical offset,
// where offset 0 is the byte at the current write position. An item comes
// in on the req_ channel, with the operation code in req_tuser, and exactly
// one result item leaves on the rsp_ channel for each item taken.
// Append stores a byte and advances the write position. Read returns the
// byte at one offset. Find walks the run from offset_a for the searched
// byte and reports the first hit. Compare walks two runs side by side and
// reports the first byte difference.
// Append skips the walk. Read walks a single byte; find and compare walk a
// run whose length is clipped to the window end. The walk reads one byte
// per cycle from a memory with two registered read ports and stops at the
// first hit; it sets the rate. One item at a time; the next is taken in
// the cycle after load. After reset the memory is cleared by a pass over
// all 4096 bytes, one byte per cycle, during which req_tready stays low.
// A finished result sits in an output register, so the next item is taken
// while it waits; if the receiver stalls, the following result holds in
// the datapath and no item is taken until the output register frees up.
`default_nettype none

module history_window_search_compare
   import hwsc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0 up: offset_a[11:0], offset_b[23:12], length[36:24],
   // byte_value[44:37], zero fill[47:45].
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0 up: opcode[1:0].
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Fields from bit 0 up: found[0], match_offset[12:1], read_byte[20:13],
   // compare_diff[29:21] (signed), zero fill[31:30].
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   cmd_type             cmd;
   sts_type             sts;
   op_type              req_opcode;
   logic [OFFSET_W-1:0] req_offset_a;
   logic [OFFSET_W-1:0] req_offset_b;
   logic [LENGTH_W-1:0] req_length;
   logic [BYTE_W-1:0]   req_byte_value;
   result_type          rsp_result;

   // Unpack the incoming item.
   assign req_opcode     = op_type'(req_tuser);
   assign req_offset_a   = req_tdata[11:0];
   assign req_offset_b   = req_tdata[23:12];
   assign req_length     = req_tdata[36:24];
   assign req_byte_value = req_tdata[44:37];

   // The result struct already has found in the lowest bit.
   assign rsp_tdata = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, rsp_result};

   hwsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   hwsc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_opcode     (req_opcode),
      .req_offset_a   (req_offset_a),
      .req_offset_b   (req_offset_b),
      .req_length     (req_length),
      .req_byte_value (req_byte_value),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_result     (rsp_result)
   );

endmodule

`default_nettype wire

FILE: src/hwsc_ctrl.sv
// Controller state machine that sequences clearing, item intake, the byte walk and result hand-off.
`default_nettype none

module hwsc_ctrl
   import hwsc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire op_type  req_opcode,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.clear_en = 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               if (req_opcode == OP_APPEND) begin
                  cmd.do_append = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.walk_en = 1'b1;
            if (sts.walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && sts.walk_done) |=> (state_ff == ST_DONE))
      else $error("walk finished but controller did not move to result hand-off");

   a_append_skips_walk: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && req_opcode == OP_APPEND) |=> (state_ff == ST_DONE))
      else $error("append item did not go straight to result hand-off");

   a_handoff_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && sts.out_free) |=> (state_ff == ST_IDLE))
      else $error("result hand-off did not return to idle");
`endif

endmodule

`default_nettype wire

FILE: src/hwsc_dp.sv
// Datapath: history memory, write position, byte walk counters, result and output registers.
`default_nettype none

module hwsc_dp
   import hwsc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   input  wire op_type              req_opcode,
   input  wire logic [OFFSET_W-1:0] req_offset_a,
   input  wire logic [OFFSET_W-1:0] req_offset_b,
   input  wire logic [LENGTH_W-1:0] req_length,
   input  wire logic [BYTE_W-1:0]   req_byte_value,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output result_type               rsp_result
);

   logic [BYTE_W-1:0] mem [WINDOW_SIZE];

   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [LEN_W-1:0]  clear_cnt_ff, clear_cnt_in;
   op_type            op_ff;
   logic [ADDR_W-1:0] off_a_ff, base_a_ff, base_b_ff;
   logic [BYTE_W-1:0] val_ff;
   logic [LEN_W-1:0]  n_ff, n_in;
   logic [LEN_W-1:0]  issue_ff, issue_in;
   logic [LEN_W-1:0]  pend_idx_ff;
   logic              pend_valid_ff, pend_valid_in;
   logic [BYTE_W-1:0] rd_a_ff, rd_b_ff;
   result_type        work_ff, work_in;
   result_type        rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [ADDR_W-1:0] off_a_m, off_b_m;
   logic [LEN_W-1:0]  room_a, room_b, len_m, n_find, n_cmp;
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic              hit_cond, hit_now, issue_go;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;

   // Run length clipped to the window end, for compare also to the second run.
   always_comb begin
      off_a_m = ADDR_W'(req_offset_a);
      off_b_m = ADDR_W'(req_offset_b);
      room_a  = LEN_W'(WINDOW_SIZE) - {1'b0, off_a_m};
      room_b  = LEN_W'(WINDOW_SIZE) - {1'b0, off_b_m};
      len_m   = LEN_W'(req_length);
      n_find  = (len_m > room_a) ? room_a : len_m;
      n_cmp   = (n_find > room_b) ? room_b : n_find;
      case (req_opcode)
         OP_READ:    n_in = LEN_W'(1);
         OP_FIND:    n_in = n_find;
         OP_COMPARE: n_in = n_cmp;
         default:    n_in = '0;
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_READ:    hit_cond = 1'b1;
         OP_FIND:    hit_cond = (rd_a_ff == val_ff);
         OP_COMPARE: hit_cond = (rd_a_ff != rd_b_ff);
         default:    hit_cond = 1'b0;
      endcase
      hit_now       = cmd.walk_en && pend_valid_ff && hit_cond;
      issue_go      = cmd.walk_en && (issue_ff < n_ff) && !hit_now;
      pend_valid_in = issue_go;
      issue_in      = cmd.start ? '0 : (issue_go ? issue_ff + LEN_W'(1) : issue_ff);
      addr_a        = base_a_ff + ADDR_W'(issue_ff);
      addr_b        = base_b_ff + ADDR_W'(issue_ff);
   end

   always_comb begin
      work_in = work_ff;
      if (cmd.start) begin
         work_in = '0;
      end else if (hit_now) begin
         case (op_ff)
            OP_READ: begin
               work_in.read_byte = rd_a_ff;
            end
            OP_FIND: begin
               work_in.found        = 1'b1;
               work_in.match_offset = OFFSET_W'({1'b0, off_a_ff} + pend_idx_ff);
            end
            OP_COMPARE: begin
               work_in.compare_diff = {1'b0, rd_a_ff} - {1'b0, rd_b_ff};
            end
            default: begin
               work_in = work_ff;
            end
         endcase
      end
   end

   always_comb begin
      wp_in        = cmd.do_append ? wp_ff + ADDR_W'(1) : wp_ff;
      clear_cnt_in = cmd.clear_en ? clear_cnt_ff + LEN_W'(1) : clear_cnt_ff;
      mem_we       = cmd.clear_en || cmd.do_append;
      mem_waddr    = cmd.clear_en ? clear_cnt_ff[ADDR_W-1:0] : wp_ff;
      mem_wdata    = cmd.clear_en ? '0 : req_byte_value;
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         clear_cnt_ff  <= '0;
         pend_valid_ff <= 1'b0;
         issue_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wp_ff         <= wp_in;
         clear_cnt_ff  <= clear_cnt_in;
         pend_valid_ff <= pend_valid_in;
         issue_ff      <= issue_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff     <= req_opcode;
         off_a_ff  <= off_a_m;
         base_a_ff <= wp_ff + off_a_m;
         base_b_ff <= wp_ff + off_b_m;
         val_ff    <= req_byte_value;
         n_ff      <= n_in;
      end
      if (issue_go) begin
         pend_idx_ff <= issue_ff;
      end
      work_ff <= work_in;
      if (cmd.load_out) begin
         rsp_ff <= work_ff;
      end
   end

   assign sts.clear_done = clear_cnt_ff[ADDR_W];
   assign sts.walk_done  = hit_now || (!pend_valid_ff && (issue_ff == n_ff));
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_result     = rsp_ff;

`ifndef NO_ASSERTIONS
   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_en) |-> (issue_ff <= n_ff))
      else $error("walk issued reads beyond the run length");

   a_append_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_append) |=> (wp_ff == $past(wp_ff) + ADDR_W'(1)))
      else $error("write position did not advance after append");

   a_pend_from_issue: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff) |-> ($past(cmd.walk_en)))
      else $error("read data marked valid without a walk read");
`endif

endmodule

`default_nettype wire
